// ----- design/fdsm_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsm_pkg
// Types, opcodes and constants for the multiplexed four-digit display driver.
// ----------------------------------------------------------------------------
package fdsm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TICK = 2'd1,
    OP_STOP = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] number;
  } item_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [3:0] digit_enables_n;
  } result_t;

  localparam int unsigned ValueW   = 14;
  localparam logic [ValueW-1:0] VALUE_MAX = 14'd9999;
  localparam logic [3:0]  ALL_DIGITS_OFF = 4'hF;

  // reciprocal multipliers, exact for values up to 9999
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam logic [15:0] RECIP_100  = 16'd5243;
  localparam logic [15:0] RECIP_1000 = 16'd8389;

  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h5F;
      4'd1:    pat = 7'h11;
      4'd2:    pat = 7'h3E;
      4'd3:    pat = 7'h3D;
      4'd4:    pat = 7'h71;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h6F;
      4'd7:    pat = 7'h19;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h7D;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ----- design/four_digit_seven_segment_mux.sv -----
// ----------------------------------------------------------------------------
// four_digit_seven_segment_mux
// Throughput: one item per cycle while the result side does not stall, through
// a two-stage divide and lookup pipe (reciprocal multiplies, then digit
// subtract and segment table).
// Reset clears the shown value and scan position, turns all segments off and
// drives every digit enable high (off).
// ----------------------------------------------------------------------------
module four_digit_seven_segment_mux import fdsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [ValueW-1:0] shown_value;
  logic [1:0]        scan_position;

  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [ValueW-1:0] s1_value;
  logic [1:0]        s1_pos;

  logic              s2_valid;
  logic [1:0]        s2_op;
  logic [1:0]        s2_pos;
  logic [ValueW-1:0] s2_lo;
  logic [9:0]        s2_hi;

  logic [6:0]        segment_pins;
  logic [3:0]        digit_pins;

  logic              accept;
  logic              out_free;
  logic              s2_move;
  logic              s1_move;
  logic [ValueW-1:0] clamped;

  logic [29:0]       prod_10;
  logic [29:0]       prod_100;
  logic [29:0]       prod_1000;
  logic [9:0]        q10;
  logic [6:0]        q100;
  logic [3:0]        q1000;
  logic [ValueW-1:0] lo_next;
  logic [9:0]        hi_next;

  logic [ValueW-1:0] digit_full;
  logic [3:0]        digit;
  logic              lit;
  logic [3:0]        digit_mask;

  assign out_free   = !result_valid || !result_stall;
  assign s2_move    = s2_valid && out_free;
  assign s1_move    = s1_valid && (!s2_valid || s2_move);
  assign item_stall = s1_valid && !s1_move;
  assign accept     = item_valid && !item_stall;

  // clamp to 0..9999
  always_comb begin
    if (item.number[15]) begin
      clamped = '0;
    end else if (item.number[14:0] > 15'(VALUE_MAX)) begin
      clamped = VALUE_MAX;
    end else begin
      clamped = item.number[ValueW-1:0];
    end
  end

  // divide by 10, 100, 1000
  always_comb begin
    prod_10   = 30'(s1_value) * 30'(RECIP_10);
    prod_100  = 30'(s1_value) * 30'(RECIP_100);
    prod_1000 = 30'(s1_value) * 30'(RECIP_1000);
    q10       = prod_10[28:19];
    q100      = prod_100[25:19];
    q1000     = prod_1000[26:23];
    case (s1_pos)
      2'd0: begin
        lo_next = s1_value;
        hi_next = q10;
      end
      2'd1: begin
        lo_next = 14'(q10);
        hi_next = 10'(q100);
      end
      2'd2: begin
        lo_next = 14'(q100);
        hi_next = 10'(q1000);
      end
      default: begin
        lo_next = 14'(q1000);
        hi_next = '0;
      end
    endcase
  end

  // digit = lo - 10 * hi, leading zeros blanked
  always_comb begin
    digit_full = s2_lo - {1'b0, s2_hi, 3'b000} - {3'b000, s2_hi, 1'b0};
    digit      = digit_full[3:0];
    lit        = (s2_pos == 2'd0) || (s2_lo != '0);
    digit_mask = ALL_DIGITS_OFF;
    digit_mask[2'd3 - s2_pos] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_value   <= '0;
      scan_position <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      result_valid  <= 1'b0;
      segment_pins  <= '0;
      digit_pins    <= ALL_DIGITS_OFF;
    end else begin
      if (accept) begin
        case (item.opcode)
          OP_LOAD: shown_value   <= clamped;
          OP_TICK: scan_position <= scan_position + 2'd1;
          default: ;
        endcase
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end

      if (s2_move) begin
        result_valid <= 1'b1;
        case (s2_op)
          OP_TICK: begin
            segment_pins <= lit ? seg_pattern(digit) : 7'h00;
            digit_pins   <= digit_mask;
          end
          OP_STOP: digit_pins <= ALL_DIGITS_OFF;
          default: ;
        endcase
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= item.opcode;
      s1_value <= shown_value;
      s1_pos   <= scan_position;
    end
    if (s1_move) begin
      s2_op  <= s1_op;
      s2_pos <= s1_pos;
      s2_lo  <= lo_next;
      s2_hi  <= hi_next;
    end
  end

  assign result.segments        = segment_pins;
  assign result.digit_enables_n = digit_pins;

endmodule

// ----- test/fdsm_pins_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsm_pins_checker
// Watches both channels of the four-digit display mux. Each accepted item beat
// advances a private copy of the display state (shown value, scan position,
// segment and digit pins), and the resulting pin levels are queued. Each
// accepted result beat is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module fdsm_pins_checker import fdsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      mismatches,
  output int      expected_left
);

  logic [ValueW-1:0] shown_value;
  logic [1:0]        scan_pos;
  logic [6:0]        seg_pins;
  logic [3:0]        digit_pins_n;
  result_t           expected_pins_q[$];

  // segment wiring of this board, bit0 = A .. bit6 = G
  function automatic logic [6:0] digit_to_segments(input int unsigned digit);
    case (digit)
      0:       return 7'b1011111;
      1:       return 7'b0010001;
      2:       return 7'b0111110;
      3:       return 7'b0111101;
      4:       return 7'b1110001;
      5:       return 7'b1101101;
      6:       return 7'b1101111;
      7:       return 7'b0011001;
      8:       return 7'b1111111;
      default: return 7'b1111101;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic advance_display(input item_t it);
    int          num;
    int unsigned v;
    int unsigned digit;
    logic        lit;
    num = $signed(it.number);
    case (it.opcode)
      OP_LOAD: begin
        if (num < 0) begin
          shown_value = '0;
        end else if (num > int'(VALUE_MAX)) begin
          shown_value = VALUE_MAX;
        end else begin
          shown_value = num[ValueW-1:0];
        end
      end
      OP_TICK: begin
        v = shown_value;
        case (scan_pos)
          2'd0: begin
            digit = v % 10;
            lit = 1'b1;
          end
          2'd1: begin
            digit = (v / 10) % 10;
            lit = v >= 10;
          end
          2'd2: begin
            digit = (v / 100) % 10;
            lit = v >= 100;
          end
          default: begin
            digit = (v / 1000) % 10;
            lit = v >= 1000;
          end
        endcase
        seg_pins = lit ? digit_to_segments(digit) : 7'd0;
        // rightmost digit sits on bit3, leftmost on bit0
        digit_pins_n = ALL_DIGITS_OFF;
        digit_pins_n[3 - int'(scan_pos)] = 1'b0;
        scan_pos = scan_pos + 2'd1;
      end
      OP_STOP: begin
        digit_pins_n = ALL_DIGITS_OFF;
      end
      default: begin
      end
    endcase
    expected_pins_q.push_back('{segments: seg_pins, digit_enables_n: digit_pins_n});
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shown_value = '0;
      scan_pos = '0;
      seg_pins = '0;
      digit_pins_n = ALL_DIGITS_OFF;
      expected_pins_q.delete();
      mismatches = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pins_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", result, 0);
        end else begin
          want = expected_pins_q.pop_front();
          if (result.segments !== want.segments) begin
            report_mismatch("segments", result.segments, want.segments);
          end
          if (result.digit_enables_n !== want.digit_enables_n) begin
            report_mismatch("digit_enables_n", result.digit_enables_n, want.digit_enables_n);
          end
        end
      end
      if (item_valid && !item_stall) begin
        advance_display(item);
      end
    end
    expected_left <= expected_pins_q.size();
  end

endmodule

// ----- test/tb_four_digit_seven_segment_mux.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_digit_seven_segment_mux
// Drives the display mux with a directed run over clamping, blanking and all
// scan positions, then random load, tick, stop and unused beats with bursty
// idling on both sides and one long result hold-off. Checking is done by
// fdsm_pins_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_four_digit_seven_segment_mux;
  import fdsm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RandomBeats    = 525;
  localparam int CalmBeats      = 60;
  localparam int HoldOffCycles  = 64;
  localparam int TailCycles     = 8;
  localparam int WatchdogLimit  = 2000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  logic calm = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   expected_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_digit_seven_segment_mux dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  fdsm_pins_checker pins_chk (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  // receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      result_stall <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      result_stall <= 1'b1;
      stall_left <= HoldOffCycles;
      hold_off_done <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_item(input logic [1:0] op, input int num);
    item_t it;
    it.opcode = op;
    it.number = 16'(num);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.number = 16'($urandom);
    if (pick < 50) begin
      it.opcode = OP_TICK;
    end else if (pick < 80) begin
      it.opcode = OP_LOAD;
      case ($urandom_range(0, 4))
        0:       it.number = 16'($urandom_range(0, 9));
        1:       it.number = 16'($urandom_range(10, 99));
        2:       it.number = 16'($urandom_range(100, 999));
        3:       it.number = 16'($urandom_range(1000, 9999));
        default: begin
        end
      endcase
    end else if (pick < 92) begin
      it.opcode = OP_STOP;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_beat(input item_t it);
    logic taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero shows only the units digit
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_LOAD, 32767));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_STOP, 0));
    send_beat(make_item(OP_UNUSED, 16'h5555));
    send_beat(make_item(OP_LOAD, -32768));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_LOAD, 10000));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_LOAD, 99));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_LOAD, 999));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_LOAD, 1000));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_LOAD, -1));
    send_beat(make_item(OP_TICK, 0));
    send_beat(make_item(OP_UNUSED, 16'hAAAA));
    send_beat(make_item(OP_STOP, 16'h7FFF));

    for (n = 0; n < RandomBeats; n++) begin
      if (n == RandomBeats / 3) begin
        hold_off_req <= 1'b1;
      end
      if (n == RandomBeats - CalmBeats) begin
        calm <= 1'b1;
      end
      send_beat(random_item());
    end
    item_valid <= 1'b0;

    do @(posedge clk); while (expected_left != 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fdsm_pkg.sv
design/four_digit_seven_segment_mux.sv
test/fdsm_pins_checker.sv
test/tb_four_digit_seven_segment_mux.sv
